FILE: src/first_order_ladrc_core_assert.svh
// assertion macros shared by the ladrc rtl
`ifndef FIRST_ORDER_LADRC_CORE_ASSERT_SVH
`define FIRST_ORDER_LADRC_CORE_ASSERT_SVH

// clocked assertion with asynchronous active-low reset as disable
`define LADRC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication form built on the clocked assertion
`define LADRC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  `LADRC_ASSERT(name, clk, rstn, (ante) |-> (cons), msg)

// next-cycle implication form
`define LADRC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  `LADRC_ASSERT(name, clk, rstn, (ante) |=> (cons), msg)

`endif

FILE: src/ladrc_pkg.sv
// shared types, constants, microprogram and saturating adder for the ladrc core
package ladrc_pkg;

  localparam int DATA_WIDTH = 48;
  localparam int FRAC_BITS  = 24;
  localparam int GAIN_W     = DATA_WIDTH - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int PROG_LEN   = 16;
  localparam int PC_W       = $clog2(PROG_LEN);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [GAIN_W-1:0]            gain_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [PC_W-1:0]              pc_t;

  localparam data_t VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // register indexes
  localparam cfg_idx_t REG_STEP_TIME    = cfg_idx_t'(0);
  localparam cfg_idx_t REG_PLANT_GAIN   = cfg_idx_t'(1);
  localparam cfg_idx_t REG_OBSERVER_BW  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_CONTROL_BW   = cfg_idx_t'(3);
  localparam cfg_idx_t REG_OUTPUT_UPPER = cfg_idx_t'(4);
  localparam cfg_idx_t REG_OUTPUT_LOWER = cfg_idx_t'(5);

  // reset values, raw fixed-point codes
  localparam gain_t RST_STEP_TIME    = gain_t'(64'd16777);
  localparam gain_t RST_PLANT_GAIN   = gain_t'(64'd1677721600000);
  localparam gain_t RST_OBSERVER_BW  = gain_t'(64'd3355443200);
  localparam gain_t RST_CONTROL_BW   = gain_t'(64'd335544320);
  localparam data_t RST_OUTPUT_UPPER = data_t'(64'sd134217728);
  localparam data_t RST_OUTPUT_LOWER = data_t'(-64'sd134217728);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT_MUL,
    ST_WAIT_DIV,
    ST_CLAMP
  } state_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    SRC_WO,
    SRC_WC,
    SRC_H,
    SRC_B0,
    SRC_REF,
    SRC_Y,
    SRC_Z1,
    SRC_Z2,
    SRC_U,
    SRC_B1,
    SRC_B2,
    SRC_E,
    SRC_ACC,
    SRC_TMP
  } src_e;

  typedef enum logic [2:0] {
    DST_B1,
    DST_B2,
    DST_E,
    DST_ACC,
    DST_TMP,
    DST_Z1,
    DST_Z2
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    dst_e dst;
  } uop_t;

  typedef struct packed {
    logic  start;
    data_t a;
    data_t b;
  } mul_req_t;

  typedef struct packed {
    logic  start;
    data_t num;
    gain_t den;
  } div_req_t;

  // observer update followed by the control law
  function automatic uop_t uop_at(pc_t pc);
    uop_t u;
    case (pc)
      pc_t'(0):  u = '{OP_ADD, SRC_WO,  SRC_WO,  DST_B1};
      pc_t'(1):  u = '{OP_MUL, SRC_WO,  SRC_WO,  DST_B2};
      pc_t'(2):  u = '{OP_SUB, SRC_Y,   SRC_Z1,  DST_E};
      pc_t'(3):  u = '{OP_MUL, SRC_B1,  SRC_E,   DST_ACC};
      pc_t'(4):  u = '{OP_ADD, SRC_ACC, SRC_Z2,  DST_ACC};
      pc_t'(5):  u = '{OP_MUL, SRC_B0,  SRC_U,   DST_TMP};
      pc_t'(6):  u = '{OP_ADD, SRC_ACC, SRC_TMP, DST_ACC};
      pc_t'(7):  u = '{OP_MUL, SRC_H,   SRC_ACC, DST_TMP};
      pc_t'(8):  u = '{OP_ADD, SRC_Z1,  SRC_TMP, DST_Z1};
      pc_t'(9):  u = '{OP_MUL, SRC_B2,  SRC_E,   DST_TMP};
      pc_t'(10): u = '{OP_MUL, SRC_H,   SRC_TMP, DST_TMP};
      pc_t'(11): u = '{OP_ADD, SRC_Z2,  SRC_TMP, DST_Z2};
      pc_t'(12): u = '{OP_SUB, SRC_REF, SRC_Z1,  DST_TMP};
      pc_t'(13): u = '{OP_MUL, SRC_WC,  SRC_TMP, DST_ACC};
      pc_t'(14): u = '{OP_SUB, SRC_ACC, SRC_Z2,  DST_ACC};
      default:   u = '{OP_DIV, SRC_ACC, SRC_ACC, DST_ACC};
    endcase
    return u;
  endfunction

  function automatic data_t sat_addsub(data_t a, data_t b, logic sub);
    logic [DATA_WIDTH:0] s;
    data_t r;
    if (sub) begin
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    end else begin
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    end
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      r = s[DATA_WIDTH] ? VMIN : VMAX;
    end else begin
      r = s[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/first_order_ladrc_core.sv
// top level of the first-order ladrc core: config registers, sequencer, shared adder
// usage:
//   s_axis carries one sample word (setpoint, measured); m_axis returns one drive word.
//   cfg port writes the six gain and limit registers, always ready; write only when idle.
//   a microprogram of sixteen steps runs on one saturating adder, one iterative
//   multiplier (four half-width partial products per multiply) and one serial
//   divider (one quotient bit per cycle, 72 bits).
//   from an accepted sample to drive valid the sequencer runs eight adds and
//   subtracts, seven multiplies, the divide and a clamp step; the divide takes longest.
//   s_axis_tready is high only while the sequencer is idle, so a new sample is not
//   taken until the sequencer is through with the last one.
//   the drive word sits in an output register; a new sample may be taken while it
//   waits, and the sequencer holds in its clamp step until m_axis frees the register.
//   reset loads the register defaults and clears both observer states and the last
//   drive to zero; there is no clearing pass.
`include "first_order_ladrc_core_assert.svh"

module first_order_ladrc_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [2*ladrc_pkg::DATA_WIDTH-1:0]   s_axis_tdata,  // setpoint, measured
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ladrc_pkg::DATA_WIDTH-1:0]     m_axis_tdata,  // drive
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  ladrc_pkg::cfg_idx_t                  cfg_index_i,
  input  logic [ladrc_pkg::DATA_WIDTH-1:0]     cfg_data_i
);

  localparam int DW = ladrc_pkg::DATA_WIDTH;
  localparam int GW = ladrc_pkg::GAIN_W;

  ladrc_pkg::gain_t   step_time_q, plant_gain_q, observer_bw_q, control_bw_q;
  ladrc_pkg::data_t   output_upper_q, output_lower_q;
  ladrc_pkg::data_t   z1_q, z2_q, u_q;
  ladrc_pkg::data_t   ref_q, y_q, b1_q, b2_q, e_q, acc_q, tmp_q;
  ladrc_pkg::data_t   m_data_q;
  logic               m_valid_q;
  ladrc_pkg::state_e  state_q, state_d;
  ladrc_pkg::pc_t     pc_q;

  ladrc_pkg::uop_t    uop;
  ladrc_pkg::data_t   op_a, op_b, alu_res, wb_data, div_q, clamped;
  logic               wb_en, out_load, in_fire;
  logic               mul_done, div_done;
  ladrc_pkg::mul_req_t mul_req;
  ladrc_pkg::div_req_t div_req;
  ladrc_pkg::data_t   mul_p;

  assign uop         = ladrc_pkg::uop_at(pc_q);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  function automatic ladrc_pkg::data_t pick(ladrc_pkg::src_e s,
                                            ladrc_pkg::gain_t wo, ladrc_pkg::gain_t wc,
                                            ladrc_pkg::gain_t h, ladrc_pkg::gain_t b0,
                                            ladrc_pkg::data_t rf, ladrc_pkg::data_t y,
                                            ladrc_pkg::data_t z1, ladrc_pkg::data_t z2,
                                            ladrc_pkg::data_t u, ladrc_pkg::data_t b1,
                                            ladrc_pkg::data_t b2, ladrc_pkg::data_t e,
                                            ladrc_pkg::data_t acc, ladrc_pkg::data_t tmp);
    ladrc_pkg::data_t r;
    case (s)
      ladrc_pkg::SRC_WO:  r = {1'b0, wo};
      ladrc_pkg::SRC_WC:  r = {1'b0, wc};
      ladrc_pkg::SRC_H:   r = {1'b0, h};
      ladrc_pkg::SRC_B0:  r = {1'b0, b0};
      ladrc_pkg::SRC_REF: r = rf;
      ladrc_pkg::SRC_Y:   r = y;
      ladrc_pkg::SRC_Z1:  r = z1;
      ladrc_pkg::SRC_Z2:  r = z2;
      ladrc_pkg::SRC_U:   r = u;
      ladrc_pkg::SRC_B1:  r = b1;
      ladrc_pkg::SRC_B2:  r = b2;
      ladrc_pkg::SRC_E:   r = e;
      ladrc_pkg::SRC_ACC: r = acc;
      ladrc_pkg::SRC_TMP: r = tmp;
      default:            r = '0;
    endcase
    return r;
  endfunction

  assign op_a = pick(uop.a, observer_bw_q, control_bw_q, step_time_q, plant_gain_q,
                     ref_q, y_q, z1_q, z2_q, u_q, b1_q, b2_q, e_q, acc_q, tmp_q);
  assign op_b = pick(uop.b, observer_bw_q, control_bw_q, step_time_q, plant_gain_q,
                     ref_q, y_q, z1_q, z2_q, u_q, b1_q, b2_q, e_q, acc_q, tmp_q);

  assign alu_res = ladrc_pkg::sat_addsub(op_a, op_b, uop.op == ladrc_pkg::OP_SUB);

  // upper limit is tested first
  assign clamped = (div_q > output_upper_q) ? output_upper_q :
                   ((div_q < output_lower_q) ? output_lower_q : div_q);

  ladrc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  ladrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .q_o    (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ladrc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = ladrc_pkg::ST_EXEC;
      end
      ladrc_pkg::ST_EXEC: begin
        case (uop.op)
          ladrc_pkg::OP_MUL: state_d = ladrc_pkg::ST_WAIT_MUL;
          ladrc_pkg::OP_DIV: state_d = ladrc_pkg::ST_WAIT_DIV;
          default:           state_d = ladrc_pkg::ST_EXEC;
        endcase
      end
      ladrc_pkg::ST_WAIT_MUL: begin
        if (mul_done) state_d = ladrc_pkg::ST_EXEC;
      end
      ladrc_pkg::ST_WAIT_DIV: begin
        if (div_done) state_d = ladrc_pkg::ST_CLAMP;
      end
      ladrc_pkg::ST_CLAMP: begin
        if (!m_valid_q || m_axis_tready) state_d = ladrc_pkg::ST_IDLE;
      end
      default: state_d = ladrc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    wb_en         = 1'b0;
    wb_data       = alu_res;
    out_load      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = op_a;
    mul_req.b     = op_b;
    div_req.start = 1'b0;
    div_req.num   = op_a;
    div_req.den   = plant_gain_q;
    case (state_q)
      ladrc_pkg::ST_IDLE: s_axis_tready = 1'b1;
      ladrc_pkg::ST_EXEC: begin
        case (uop.op)
          ladrc_pkg::OP_MUL: mul_req.start = 1'b1;
          ladrc_pkg::OP_DIV: div_req.start = 1'b1;
          default:           wb_en = 1'b1;
        endcase
      end
      ladrc_pkg::ST_WAIT_MUL: begin
        wb_en   = mul_done;
        wb_data = mul_p;
      end
      ladrc_pkg::ST_CLAMP: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ladrc_pkg::ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        pc_q <= '0;
      end else if (wb_en) begin
        pc_q <= pc_q + ladrc_pkg::pc_t'(1);
      end
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q    <= ladrc_pkg::RST_STEP_TIME;
      plant_gain_q   <= ladrc_pkg::RST_PLANT_GAIN;
      observer_bw_q  <= ladrc_pkg::RST_OBSERVER_BW;
      control_bw_q   <= ladrc_pkg::RST_CONTROL_BW;
      output_upper_q <= ladrc_pkg::RST_OUTPUT_UPPER;
      output_lower_q <= ladrc_pkg::RST_OUTPUT_LOWER;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ladrc_pkg::REG_STEP_TIME:    step_time_q    <= cfg_data_i[GW-1:0];
        ladrc_pkg::REG_PLANT_GAIN:   plant_gain_q   <= cfg_data_i[GW-1:0];
        ladrc_pkg::REG_OBSERVER_BW:  observer_bw_q  <= cfg_data_i[GW-1:0];
        ladrc_pkg::REG_CONTROL_BW:   control_bw_q   <= cfg_data_i[GW-1:0];
        ladrc_pkg::REG_OUTPUT_UPPER: output_upper_q <= cfg_data_i;
        ladrc_pkg::REG_OUTPUT_LOWER: output_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // observer states, last drive and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q      <= '0;
      z2_q      <= '0;
      u_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (wb_en && uop.dst == ladrc_pkg::DST_Z1) z1_q <= wb_data;
      if (wb_en && uop.dst == ladrc_pkg::DST_Z2) z2_q <= wb_data;
      if (out_load) begin
        u_q       <= clamped;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ref_q <= s_axis_tdata[DW-1:0];
      y_q   <= s_axis_tdata[2*DW-1:DW];
    end
    if (wb_en) begin
      case (uop.dst)
        ladrc_pkg::DST_B1:  b1_q  <= wb_data;
        ladrc_pkg::DST_B2:  b2_q  <= wb_data;
        ladrc_pkg::DST_E:   e_q   <= wb_data;
        ladrc_pkg::DST_ACC: acc_q <= wb_data;
        ladrc_pkg::DST_TMP: tmp_q <= wb_data;
        default: ;
      endcase
    end
    if (out_load) m_data_q <= clamped;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `LADRC_ASSERT_IMP(a_mul_done_waiting, clk_i, rst_ni, mul_done,
    state_q == ladrc_pkg::ST_WAIT_MUL, "multiplier finished outside a multiply wait")
  `LADRC_ASSERT_IMP(a_div_done_waiting, clk_i, rst_ni, div_done,
    state_q == ladrc_pkg::ST_WAIT_DIV, "divider finished outside a divide wait")
  `LADRC_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_fire,
    (state_q == ladrc_pkg::ST_EXEC) && (pc_q == '0), "sample accepted without program start")
  `LADRC_ASSERT_NEXT(a_clamp_holds, clk_i, rst_ni,
    (state_q == ladrc_pkg::ST_CLAMP) && m_valid_q && !m_axis_tready,
    (state_q == ladrc_pkg::ST_CLAMP) && $stable(m_data_q), "drive word overwritten while stalled")

endmodule

FILE: src/ladrc_mul.sv
// iterative saturating fixed-point multiplier built from four half-width partial products
module ladrc_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ladrc_pkg::mul_req_t req_i,
  output logic               done_o,
  output ladrc_pkg::data_t   p_o
);

  localparam int DW   = ladrc_pkg::DATA_WIDTH;
  localparam int HALF = (DW + 1) / 2;
  localparam int MW   = 2 * HALF;
  localparam int PW   = 2 * MW;

  localparam logic [2:0] STEP_LAST_PP = 3'd3;
  localparam logic [2:0] STEP_ROUND   = 3'd4;
  localparam logic [2:0] STEP_SAT     = 3'd5;

  localparam logic [PW-1:0] RND_HALF = PW'(1) << (ladrc_pkg::FRAC_BITS - 1);

  logic                busy_q, busy_d;
  logic [2:0]          step_q, step_d;
  logic                neg_q, neg_d;
  logic [MW-1:0]       xm_q, xm_d, ym_q, ym_d;
  logic [PW-1:0]       acc_q, acc_d;
  logic                done_q, done_d;
  ladrc_pkg::data_t    p_q, p_d;

  logic [DW-1:0]       amag, bmag;
  logic [HALF-1:0]     xs, ys;
  logic [MW-1:0]       pp;
  logic [1:0]          shamt;
  logic [PW-1:0]       sh;
  logic                fits;

  assign amag  = req_i.a[DW-1] ? (~req_i.a + DW'(1)) : req_i.a;
  assign bmag  = req_i.b[DW-1] ? (~req_i.b + DW'(1)) : req_i.b;
  assign xs    = step_q[0] ? xm_q[MW-1:HALF] : xm_q[HALF-1:0];
  assign ys    = step_q[1] ? ym_q[MW-1:HALF] : ym_q[HALF-1:0];
  assign pp    = xs * ys;
  assign shamt = {1'b0, step_q[0]} + {1'b0, step_q[1]};
  assign sh    = $signed(acc_q) >>> ladrc_pkg::FRAC_BITS;
  assign fits  = (sh[PW-1:DW-1] == '0) || (sh[PW-1:DW-1] == '1);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    neg_d  = neg_q;
    xm_d   = xm_q;
    ym_d   = ym_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    p_d    = p_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = req_i.a[DW-1] ^ req_i.b[DW-1];
      xm_d   = MW'(amag);
      ym_d   = MW'(bmag);
      acc_d  = '0;
    end else if (busy_q) begin
      if (step_q <= STEP_LAST_PP) begin
        acc_d  = acc_q + (PW'(pp) << (HALF * int'(shamt)));
        step_d = step_q + 3'd1;
      end else if (step_q == STEP_ROUND) begin
        acc_d  = neg_q ? (~acc_q + RND_HALF + PW'(1)) : (acc_q + RND_HALF);
        step_d = STEP_SAT;
      end else begin
        p_d    = fits ? sh[DW-1:0] : (acc_q[PW-1] ? ladrc_pkg::VMIN : ladrc_pkg::VMAX);
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    xm_q  <= xm_d;
    ym_q  <= ym_d;
    acc_q <= acc_d;
    p_q   <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

FILE: src/ladrc_div.sv
// serial restoring divider for (num << frac) / gain, one quotient bit per cycle, saturating
module ladrc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ladrc_pkg::div_req_t req_i,
  output logic                done_o,
  output ladrc_pkg::data_t    q_o
);

  localparam int DW    = ladrc_pkg::DATA_WIDTH;
  localparam int GW    = ladrc_pkg::GAIN_W;
  localparam int NW    = DW + ladrc_pkg::FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);

  localparam logic [NW-1:0] QMAX     = NW'(ladrc_pkg::VMAX);
  localparam logic [NW-1:0] QMIN_MAG = NW'(1) << (DW - 1);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic [GW-1:0]       rem_q, rem_d;
  logic [NW-1:0]       dvd_q, dvd_d;
  ladrc_pkg::gain_t    den_q, den_d;
  logic                done_q, done_d;
  ladrc_pkg::data_t    q_q, q_d;

  logic [DW-1:0]       nmag;
  logic [DW-1:0]       remsh;
  logic                ge;
  logic [DW-1:0]       diff;

  assign nmag  = req_i.num[DW-1] ? (~req_i.num + DW'(1)) : req_i.num;
  assign remsh = {rem_q, dvd_q[NW-1]};
  assign ge    = remsh >= {1'b0, den_q};
  assign diff  = remsh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    den_d  = den_q;
    done_d = 1'b0;
    q_d    = q_q;
    if (req_i.start) begin
      neg_d = req_i.num[DW-1];
      den_d = req_i.den;
      rem_d = '0;
      dvd_d = NW'(nmag) << ladrc_pkg::FRAC_BITS;
      cnt_d = CNT_W'(NW);
      if (req_i.den == '0) begin
        // zero gain gives the rail in the sign of the numerator
        if (req_i.num[DW-1]) begin
          q_d = ladrc_pkg::VMIN;
        end else if (req_i.num != '0) begin
          q_d = ladrc_pkg::VMAX;
        end else begin
          q_d = '0;
        end
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = ge ? diff[GW-1:0] : remsh[GW-1:0];
        dvd_d = {dvd_q[NW-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
      end else begin
        if (!neg_q) begin
          q_d = (dvd_q > QMAX) ? ladrc_pkg::VMAX : dvd_q[DW-1:0];
        end else begin
          q_d = (dvd_q > QMIN_MAG) ? ladrc_pkg::VMIN : (~dvd_q[DW-1:0] + DW'(1));
        end
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    den_q <= den_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the first-order ladrc core with its own fixed-point controller
module tb;
  import ladrc_pkg::*;

  localparam int          LIMIT_CYCLES = 2000000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          PHASE_ITEMS  = 170;
  localparam cfg_idx_t    IDX_UNMAPPED_LO = cfg_idx_t'(6);
  localparam cfg_idx_t    IDX_UNMAPPED_HI = cfg_idx_t'(7);
  localparam data_t       ONE_Q = data_t'(64'sd1 << FRAC_BITS);

  typedef logic signed [99:0] wide_t;

  typedef struct packed {
    data_t setpoint;
    data_t measured;
  } sample_t;

  typedef enum logic [2:0] {
    CFG_REALISTIC,
    CFG_MAXED,
    CFG_MINIMAL,
    CFG_WILD,
    CFG_INVERTED,
    CFG_DEFAULTS
  } setting_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [2*DATA_WIDTH-1:0]   s_axis_tdata = '0;  // setpoint, measured
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [DATA_WIDTH-1:0]     m_axis_tdata;       // drive
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  cfg_idx_t                  cfg_index_i = REG_STEP_TIME;
  logic [DATA_WIDTH-1:0]     cfg_data_i = '0;

  // controller state and registers as the block should hold them
  gain_t step_h   = RST_STEP_TIME;
  gain_t plant_b0 = RST_PLANT_GAIN;
  gain_t obs_bw   = RST_OBSERVER_BW;
  gain_t ctl_bw   = RST_CONTROL_BW;
  data_t lim_hi   = RST_OUTPUT_UPPER;
  data_t lim_lo   = RST_OUTPUT_LOWER;
  data_t z_out      = '0;
  data_t z_dist     = '0;
  data_t prev_drive = '0;

  sample_t     pending_samples[$];
  data_t       expected_drive[$];
  sample_t     cur_sample;
  int          samples_queued = 0;
  int          samples_taken = 0;
  int          drives_seen = 0;
  int          error_count = 0;
  int          stall_left = 0;
  bit          stall_done = 1'b0;
  int unsigned cycle_count = 0;

  first_order_ladrc_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic data_t clip(wide_t v);
    if (v > wide_t'(VMAX)) return VMAX;
    if (v < wide_t'(VMIN)) return VMIN;
    return data_t'(v[DATA_WIDTH-1:0]);
  endfunction

  function automatic data_t sat_sum(data_t a, data_t b);
    return clip(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic data_t sat_diff(data_t a, data_t b);
    return clip(wide_t'(a) - wide_t'(b));
  endfunction

  // round half up on the dropped fraction bits
  function automatic data_t sat_prod(data_t a, data_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    p = (p + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clip(p);
  endfunction

  // truncating divide by the plant gain, rail in the sign of the numerator for zero gain
  function automatic data_t sat_quot(data_t num, gain_t den);
    wide_t n, q;
    if (den == '0) begin
      if (num > 0) return VMAX;
      if (num < 0) return VMIN;
      return '0;
    end
    n = (num < 0) ? -wide_t'(num) : wide_t'(num);
    n = n <<< FRAC_BITS;
    q = n / wide_t'({1'b0, den});
    return (num < 0) ? clip(-q) : clip(q);
  endfunction

  function automatic data_t advance_controller(data_t sp, data_t ms);
    data_t h, b0, wo, wc, beta1, beta2, err, acc, u;
    h  = data_t'({1'b0, step_h});
    b0 = data_t'({1'b0, plant_b0});
    wo = data_t'({1'b0, obs_bw});
    wc = data_t'({1'b0, ctl_bw});
    beta1 = sat_sum(wo, wo);
    beta2 = sat_prod(wo, wo);
    err = sat_diff(ms, z_out);
    acc = sat_sum(sat_prod(beta1, err), z_dist);
    acc = sat_sum(acc, sat_prod(b0, prev_drive));
    z_out  = sat_sum(z_out, sat_prod(h, acc));
    z_dist = sat_sum(z_dist, sat_prod(h, sat_prod(beta2, err)));
    acc = sat_diff(sat_prod(wc, sat_diff(sp, z_out)), z_dist);
    u = sat_quot(acc, plant_b0);
    if (u > lim_hi) begin
      u = lim_hi;
    end else if (u < lim_lo) begin
      u = lim_lo;
    end
    prev_drive = u;
    return u;
  endfunction

  function automatic int gap_pct(bit receiver);
    if (samples_taken < 620) return receiver ? 54 : 28;
    if (samples_taken < 1240) return receiver ? 28 : 54;
    return 0;
  endfunction

  function automatic data_t pick_value();
    data_t v;
    v = data_t'({$urandom, $urandom});
    case ($urandom_range(9))
      0: v = VMAX;
      1: v = VMIN;
      2: v = v >>> (DATA_WIDTH - 1);
      3, 4: ;
      default: v = v >>> $urandom_range(DATA_WIDTH - 2);
    endcase
    return v;
  endfunction

  function automatic gain_t rand_gain(int lo_bits, int hi_bits);
    gain_t v;
    v = gain_t'({$urandom, $urandom}) >> (GAIN_W - $urandom_range(hi_bits, lo_bits));
    if (v == '0) v = gain_t'(1);
    return v;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic push_sample(data_t sp, data_t ms);
    pending_samples.push_back('{setpoint: sp, measured: ms});
    samples_queued++;
  endtask

  // step-like runs: setpoint held, measurement mostly near it
  task automatic feed_random(int count);
    data_t sp, ms;
    int run_left;
    run_left = 0;
    sp = '0;
    repeat (count) begin
      if (run_left == 0) begin
        sp = pick_value();
        run_left = $urandom_range(20, 1);
      end
      run_left--;
      if ($urandom_range(9) < 6) begin
        ms = sat_sum(sp, pick_value() >>> $urandom_range(40, 16));
      end else begin
        ms = pick_value();
      end
      push_sample(sp, ms);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (drives_seen < samples_queued || !s_axis_tready);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [DATA_WIDTH-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_STEP_TIME:    step_h   = value[GAIN_W-1:0];
      REG_PLANT_GAIN:   plant_b0 = value[GAIN_W-1:0];
      REG_OBSERVER_BW:  obs_bw   = value[GAIN_W-1:0];
      REG_CONTROL_BW:   ctl_bw   = value[GAIN_W-1:0];
      REG_OUTPUT_UPPER: lim_hi   = data_t'(value);
      REG_OUTPUT_LOWER: lim_lo   = data_t'(value);
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_e s);
    gain_t h, b0, wo, wc;
    data_t hi, lo;
    h  = rand_gain(8, 22);
    b0 = rand_gain(24, 44);
    wo = rand_gain(24, 36);
    wc = rand_gain(20, 34);
    hi = data_t'({1'b0, rand_gain(20, 40)});
    lo = -data_t'({1'b0, rand_gain(20, 40)});
    case (s)
      CFG_MAXED: begin
        h = '1; b0 = '1; wo = '1; wc = '1;
        hi = VMAX; lo = VMIN;
      end
      CFG_MINIMAL: begin
        h = gain_t'(1); b0 = gain_t'(1); wo = '0; wc = '0;
        hi = VMIN; lo = VMAX;
      end
      CFG_WILD: begin
        h  = gain_t'({$urandom, $urandom});
        b0 = rand_gain(1, GAIN_W);
        wo = gain_t'({$urandom, $urandom});
        wc = gain_t'({$urandom, $urandom});
        hi = data_t'({$urandom, $urandom});
        lo = data_t'({$urandom, $urandom});
      end
      CFG_INVERTED: begin
        hi = -data_t'({1'b0, rand_gain(16, 30)});
        lo = data_t'({1'b0, rand_gain(16, 30)});
      end
      CFG_DEFAULTS: begin
        h = RST_STEP_TIME; b0 = RST_PLANT_GAIN; wo = RST_OBSERVER_BW; wc = RST_CONTROL_BW;
        hi = RST_OUTPUT_UPPER; lo = RST_OUTPUT_LOWER;
      end
      default: ;
    endcase
    cfg_write(REG_STEP_TIME, {1'($urandom_range(1)), h});
    cfg_write(REG_PLANT_GAIN, {1'($urandom_range(1)), b0});
    cfg_write(REG_OBSERVER_BW, {1'($urandom_range(1)), wo});
    cfg_write(REG_CONTROL_BW, {1'($urandom_range(1)), wc});
    cfg_write(REG_OUTPUT_UPPER, hi);
    cfg_write(REG_OUTPUT_LOWER, lo);
    if (s == CFG_WILD) begin
      cfg_write(IDX_UNMAPPED_LO, DATA_WIDTH'({$urandom, $urandom}));
      cfg_write(IDX_UNMAPPED_HI, DATA_WIDTH'({$urandom, $urandom}));
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(setting_e s);
    wait_idle();
    apply_setting(s);
    feed_random(PHASE_ITEMS);
  endtask

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_drive.push_back(advance_controller(cur_sample.setpoint, cur_sample.measured));
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= gap_pct(1'b0)) begin
          cur_sample = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_sample.measured, cur_sample.setpoint};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // drive monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        drives_seen++;
        if (expected_drive.size() == 0) begin
          flag_error($sformatf("unexpected drive word %0d", $signed(m_axis_tdata)));
        end else if (m_axis_tdata !== expected_drive[0]) begin
          flag_error($sformatf("drive mismatch: expected %0d, got %0d",
                               expected_drive[0], $signed(m_axis_tdata)));
          void'(expected_drive.pop_front());
        end else begin
          void'(expected_drive.pop_front());
        end
      end
      m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= gap_pct(1'b1));
    end
  end

  // one long output back-pressure window
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_done && samples_taken >= 400) begin
      stall_left <= 3000;
      stall_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    push_sample('0, '0);
    push_sample(VMAX, VMAX);
    push_sample(VMIN, VMIN);
    push_sample(VMAX, VMIN);
    push_sample(VMIN, VMAX);
    push_sample('0, VMAX);
    push_sample('0, VMIN);
    push_sample('0, '0);
    repeat (3) push_sample(ONE_Q, '0);
    push_sample(ONE_Q, ONE_Q >>> 1);
    repeat (2) push_sample(-ONE_Q, '0);
    push_sample(data_t'(1), -data_t'(1));
    push_sample(-data_t'(1), data_t'(1));
    push_sample(ONE_Q * 100, '0);
    repeat (2) push_sample('0, '0);
    feed_random(150);
    run_phase(CFG_REALISTIC);
    run_phase(CFG_MAXED);
    run_phase(CFG_REALISTIC);
    run_phase(CFG_MINIMAL);
    run_phase(CFG_WILD);
    run_phase(CFG_INVERTED);
    run_phase(CFG_DEFAULTS);
    run_phase(CFG_REALISTIC);
    run_phase(CFG_WILD);
    run_phase(CFG_REALISTIC);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_drive.size() != 0) begin
      flag_error($sformatf("%0d drive words never arrived", expected_drive.size()));
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
